// ===== rtl/core/lcgs_pkg.sv =====
// Shared types and constants for the cell grid step block.
`timescale 1ns / 1ps
package lcgs_pkg;

    localparam int OP_W        = 1;
    localparam int RING_W      = 32;
    localparam int CELL_W      = 6;
    localparam int IDX_W       = 5;
    localparam int VALUE_W     = 8;
    localparam int LUT_ENTRIES = 32;
    localparam int MAX_CELLS   = 64;
    localparam int STORE_DEPTH = MAX_CELLS * LUT_ENTRIES;
    localparam int ADDR_W      = CELL_W + IDX_W;

    localparam logic [OP_W-1:0] OP_STEP = 1'b0;
    localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic issue;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic credit_ok;
        logic last_cell;
        logic inflight;
    } stat_t;

endpackage

// ===== rtl/core/lcgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lcgs_ctrl.sv =====
// Controller state machine for the cell grid step block.
`timescale 1ns / 1ps
module lcgs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [lcgs_pkg::OP_W-1:0]      op,
    input  lcgs_pkg::stat_t                stat,
    output logic                           in_ready,
    output lcgs_pkg::cmd_t                 cmd
);
    import lcgs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (stat.credit_ok)
                begin
                    cmd.issue = 1'b1;
                    if (stat.last_cell)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lcgs_dpath.sv =====
// Datapath: cell rings, table memory, neighbour index and output queue.
`timescale 1ns / 1ps
module lcgs_dpath #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcgs_pkg::cmd_t                  cmd,
    output lcgs_pkg::stat_t                 stat,
    input  logic [lcgs_pkg::RING_W-1:0]     boundary_bits,
    input  logic [lcgs_pkg::CELL_W-1:0]     cell_index,
    input  logic [lcgs_pkg::IDX_W-1:0]      lut_address,
    input  logic [lcgs_pkg::VALUE_W-1:0]    lut_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [lcgs_pkg::CELL_W-1:0]     cell_number,
    output logic [lcgs_pkg::VALUE_W-1:0]    cell_value,
    output logic                            last
);
    import lcgs_pkg::*;

    localparam int N   = GRID_WIDTH * GRID_HEIGHT;
    localparam int XW  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int P_R = 1 % N;
    localparam int P_B = GRID_WIDTH % N;
    localparam int P_T = N - GRID_WIDTH;
    localparam int P_L = N - 1;
    localparam logic [IDX_W-1:0] RB_R = IDX_W'(GRID_WIDTH);
    localparam logic [IDX_W-1:0] RB_B = IDX_W'(2 * GRID_WIDTH + GRID_HEIGHT - 1);
    localparam logic [IDX_W-1:0] RB_L = IDX_W'(2 * GRID_WIDTH + 2 * GRID_HEIGHT - 1);
    localparam int QD  = 4;
    localparam int QPW = $clog2(QD);
    localparam int QCW = QPW + 1;

    logic [IDX_W-1:0]  old_reg [N];
    logic [IDX_W-1:0]  new_reg [N];
    logic [RING_W-1:0] ring_reg;
    logic [XW-1:0]     x_reg;
    logic [YW-1:0]     y_reg;
    logic [CELL_W-1:0] c_reg;
    logic              inflight_reg;
    logic [CELL_W-1:0] pend_num_reg;
    logic              pend_last_reg;

    logic [CELL_W-1:0]  q_num_reg  [QD];
    logic [VALUE_W-1:0] q_val_reg  [QD];
    logic               q_last_reg [QD];
    logic [QPW-1:0]     wr_ptr_reg;
    logic [QPW-1:0]     rd_ptr_reg;
    logic [QCW-1:0]     occ_reg;

    logic              t_bit, r_bit, b_bit, l_bit, s_bit;
    logic [IDX_W-1:0]  idx;
    logic              x_end, last_cell;
    logic [VALUE_W-1:0] rdata;
    logic              push, pop;

    assign x_end     = (x_reg == XW'(GRID_WIDTH - 1));
    assign last_cell = (c_reg == CELL_W'(N - 1));

    assign t_bit = (y_reg != '0) ? old_reg[P_T][4] : ring_reg[IDX_W'(x_reg)];
    assign r_bit = !x_end ? old_reg[P_R][3] : ring_reg[RB_R + IDX_W'(y_reg)];
    assign b_bit = (y_reg != YW'(GRID_HEIGHT - 1)) ? old_reg[P_B][2]
                                                   : ring_reg[RB_B - IDX_W'(x_reg)];
    assign l_bit = (x_reg != '0) ? old_reg[P_L][1] : ring_reg[RB_L - IDX_W'(y_reg)];
    assign s_bit = old_reg[0][0];
    assign idx   = {t_bit, r_bit, b_bit, l_bit, s_bit};

    lcgs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_lut (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr ({cell_index, lut_address}),
        .wdata (lut_value),
        .re    (cmd.issue),
        .raddr ({c_reg, idx}),
        .rdata (rdata)
    );

    // advance scan counters and track the table read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            c_reg        <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= cmd.issue;
            if (cmd.start)
            begin
                x_reg <= '0;
                y_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.issue)
            begin
                c_reg <= c_reg + CELL_W'(1);
                if (x_end)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + YW'(1);
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ring_reg <= boundary_bits;
        end
        if (cmd.issue)
        begin
            pend_num_reg  <= c_reg;
            pend_last_reg <= last_cell;
        end
    end

    // rotate the previous generation, take the new one on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                old_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < N; i++)
            begin
                old_reg[i] <= new_reg[i];
            end
        end
        else if (cmd.issue)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                old_reg[i] <= old_reg[i + 1];
            end
            old_reg[N - 1] <= old_reg[0];
        end
    end

    assign push = inflight_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                new_reg[i] <= new_reg[i + 1];
            end
            new_reg[N - 1] <= rdata[IDX_W-1:0];
            q_num_reg[wr_ptr_reg]  <= pend_num_reg;
            q_val_reg[wr_ptr_reg]  <= rdata;
            q_last_reg[wr_ptr_reg] <= pend_last_reg;
        end
    end

    assign out_valid   = (occ_reg != '0);
    assign pop         = out_valid && out_ready;
    assign cell_number = q_num_reg[rd_ptr_reg];
    assign cell_value  = q_val_reg[rd_ptr_reg];
    assign last        = q_last_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
            occ_reg <= occ_reg + QCW'(push) - QCW'(pop);
        end
    end

    assign stat.credit_ok = ((occ_reg + QCW'(inflight_reg)) <= QCW'(QD - 2));
    assign stat.last_cell = last_cell;
    assign stat.inflight  = inflight_reg;

endmodule

// ===== rtl/core/lut_cell_grid_step.sv =====
// A step reads the table once per cell through the single read port; a load word
// writes one table byte when it is accepted.
// Back-pressure on the output stalls table reads through a four-word result queue.
// Input is not ready again until a step has committed its new generation.
// Reset: the cell generation clears to zero at once; table bytes are undefined
// until loaded.
`timescale 1ns / 1ps
module lut_cell_grid_step #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lcgs_pkg::OP_W-1:0]       op,
    input  logic [lcgs_pkg::RING_W-1:0]     boundary_bits,
    input  logic [lcgs_pkg::CELL_W-1:0]     cell_index,
    input  logic [lcgs_pkg::IDX_W-1:0]      lut_address,
    input  logic [lcgs_pkg::VALUE_W-1:0]    lut_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lcgs_pkg::CELL_W-1:0]     cell_number,
    output logic [lcgs_pkg::VALUE_W-1:0]    cell_value,
    output logic                            last
);
    import lcgs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lcgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    lcgs_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .boundary_bits (boundary_bits),
        .cell_index    (cell_index),
        .lut_address   (lut_address),
        .lut_value     (lut_value),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .cell_number   (cell_number),
        .cell_value    (cell_value),
        .last          (last)
    );

    a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.credit_ok)
        else $error("table read issued without queue space");

    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !stat.inflight)
        else $error("generation committed with a read in flight");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_STEP) |=> !in_ready)
        else $error("input still ready after a step word");

    a_last_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && stat.last_cell) |=> !cmd.issue)
        else $error("table read issued past the last cell");

endmodule
